### design/c2rb_pkg.sv
// c2rb_pkg: shared types and constants of the replicate-border 2d convolution
// no dependencies

package c2rb_pkg;

    localparam int PIX_W      = 16;
    localparam int COEF_W     = 12;
    localparam int KDIM       = 5;
    localparam int SUM_W      = 33;
    localparam int PROD_W     = 29;
    localparam int ROW_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROW0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROW1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROW2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROW3  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROW4  = 3'd7;

    typedef logic [PIX_W-1:0] t_pix;

    typedef logic [KDIM-1:0][CFG_DATA_W-1:0] t_coef_rows;

    typedef struct packed {
        t_pix [KDIM-1:0] col;
        logic            first;
        logic            has;
        logic [1:0]      d0;
        logic            multi;
        logic            frame_last;
    } t_col_item;

endpackage

### design/c2rb_ram.sv
// c2rb_ram: generic single-write, single-read ram with registered read data
// no dependencies

module c2rb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/c2rb_front.sv
// c2rb_front: accepts words, tracks row and column, reads and writes the line store
// depends on c2rb_pkg and c2rb_ram

module c2rb_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_cmd,
    input  logic [c2rb_pkg::PIX_W-1:0]     i_pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_wm1,
    input  logic [15:0]                    i_h,
    input  logic [1:0]                     i_ahead,
    input  logic                           i_restart,
    input  logic                           i_full,
    output logic                           o_push,
    output c2rb_pkg::t_col_item            o_item
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = c2rb_pkg::ROW_W;

    logic [RW-1:0]               r_row;
    logic [AW-1:0]               r_col;
    logic                        r_b_vld;
    logic [RW-1:0]               r_b_row;
    logic [AW-1:0]               r_b_col;
    c2rb_pkg::t_pix              r_b_pix;
    logic                        r_b_real;
    logic                        r_b_first;
    logic                        r_b_multi;
    logic                        r_b_has;
    logic [1:0]                  r_b_d0;
    logic                        r_b_flast;
    logic                        r_fwd_hit;
    logic [1:0]                  r_fwd_bank;
    c2rb_pkg::t_pix              r_fwd_data;

    logic                        w_move;
    logic                        w_accept;
    logic                        w_real;
    logic                        w_take;
    logic                        w_multi;
    logic                        w_col_ge;
    logic [RW-1:0]               w_row_last;
    c2rb_pkg::t_pix              w_q   [4];
    c2rb_pkg::t_pix              w_rd  [1:4];
    c2rb_pkg::t_pix              w_col [5];

    assign w_move     = r_b_vld && !i_full;
    assign o_stall    = r_b_vld && i_full;
    assign w_accept   = i_valid && !o_stall;
    assign w_real     = r_row < RW'(i_h);
    assign w_take     = w_accept && (w_real ? !i_cmd : i_cmd);
    assign w_multi    = r_col == i_wm1;
    assign w_col_ge   = r_col >= AW'(i_ahead);
    assign w_row_last = RW'(i_h) - RW'(1) + RW'(i_ahead);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_row <= '0;
            r_col <= '0;
        end else if (w_take) begin
            if (w_multi) begin
                r_col <= '0;
                r_row <= (r_row == w_row_last) ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_take) begin
            r_b_vld <= 1'b1;
        end else if (w_move) begin
            r_b_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_b_row    <= r_row;
            r_b_col    <= r_col;
            r_b_pix    <= i_pixel;
            r_b_real   <= w_real;
            r_b_first  <= r_col == '0;
            r_b_multi  <= w_multi;
            r_b_has    <= (r_row >= RW'(i_ahead)) && (w_multi || w_col_ge);
            r_b_d0     <= (w_multi && !w_col_ge) ? r_col[1:0] : i_ahead;
            r_b_flast  <= w_multi && (r_row == w_row_last);
            r_fwd_hit  <= w_move && (r_b_col == r_col);
            r_fwd_bank <= r_b_row[1:0];
            r_fwd_data <= w_col[0];
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        c2rb_ram #(
            .WIDTH (c2rb_pkg::PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (w_move && (r_b_row[1:0] == 2'(b))),
            .i_waddr (r_b_col),
            .i_wdata (w_col[0]),
            .i_re    (w_take),
            .i_raddr (r_col),
            .o_rdata (w_q[b])
        );
    end

    always_comb begin
        logic [1:0] bank;
        bank = '0;
        for (int d = 1; d < 5; d++) begin
            bank = r_b_row[1:0] - 2'(d);
            w_rd[d] = (r_fwd_hit && (r_fwd_bank == bank)) ? r_fwd_data : w_q[bank];
        end
        w_col[0] = r_b_real ? r_b_pix : w_rd[1];
        for (int d = 1; d < 5; d++) begin
            w_col[d] = (RW'(d) <= r_b_row) ? w_rd[d] : w_col[d-1];
        end
    end

    always_comb begin
        for (int d = 0; d < 5; d++) begin
            o_item.col[d] = w_col[d];
        end
        o_item.first      = r_b_first;
        o_item.has        = r_b_has;
        o_item.d0         = r_b_d0;
        o_item.multi      = r_b_multi;
        o_item.frame_last = r_b_flast;
    end

    assign o_push = w_move;

`ifndef SYNTHESIS
    a_row_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(i_restart) |-> r_row <= w_row_last)
        else $error("row counter past the last drain row");
    a_col_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(i_restart) |-> r_col <= i_wm1)
        else $error("column counter past the frame width");
`endif

endmodule

### design/c2rb_fifo.sv
// c2rb_fifo: short queue of column words between front and back
// depends on c2rb_pkg

module c2rb_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  c2rb_pkg::t_col_item i_item,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_nonempty,
    output c2rb_pkg::t_col_item o_item
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    c2rb_pkg::t_col_item r_mem [DEPTH];
    logic [PW-1:0]       r_wp;
    logic [PW-1:0]       r_rp;
    logic [PW:0]         r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (PW+1)'(1);
                2'b01:   r_count <= r_count - (PW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_full     = r_count == (PW+1)'(DEPTH);
    assign o_nonempty = r_count != '0;
    assign o_item     = r_mem[r_rp];

`ifndef SYNTHESIS
    a_no_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty column queue");
    a_count_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PW+1)'(DEPTH))
        else $error("column queue count overflow");
`endif

endmodule

### design/c2rb_back.sv
// c2rb_back: 5x5 window, result sequencing and pipelined multiply-accumulate
// depends on c2rb_pkg

module c2rb_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_nonempty,
    input  c2rb_pkg::t_col_item                 i_item,
    output logic                                o_pop,
    input  logic [2:0]                          i_k,
    input  logic [1:0]                          i_half,
    input  c2rb_pkg::t_coef_rows                i_coef,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [c2rb_pkg::SUM_W-1:0]   o_filtered,
    output logic                                o_last_of_run,
    output logic                                o_last_of_frame
);

    localparam int KD = c2rb_pkg::KDIM;
    localparam int PW = c2rb_pkg::PROD_W;
    localparam int SW = c2rb_pkg::SUM_W;
    localparam int CW = c2rb_pkg::COEF_W;

    c2rb_pkg::t_pix           r_win [KD][KD];
    logic                     r_busy;
    logic [1:0]               r_d;
    logic [1:0]               r_dend;
    logic                     r_flast;

    logic                     r_p_vld;
    logic signed [PW-1:0]     r_prod [KD][KD];
    logic                     r_p_lor;
    logic                     r_p_lof;

    logic                     r_s_vld;
    logic signed [SW-1:0]     r_rsum [KD];
    logic                     r_s_lor;
    logic                     r_s_lof;

    logic                     r_o_vld;
    logic signed [SW-1:0]     r_o_sum;
    logic                     r_o_lor;
    logic                     r_o_lof;

    logic                     w_en;
    logic                     w_last;
    logic                     w_pop;
    logic signed [PW-1:0]     w_prod [KD][KD];
    logic signed [SW-1:0]     w_rsum [KD];
    logic signed [SW-1:0]     w_total;

    assign w_en   = !r_o_vld || !i_stall;
    assign w_last = r_d == r_dend;
    assign w_pop  = i_nonempty && w_en && (!r_busy || w_last);
    assign o_pop  = w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_pop) begin
            r_busy <= i_item.has;
        end else if (w_en && r_busy && w_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_d     <= i_item.d0;
            r_dend  <= i_item.multi ? 2'd0 : i_item.d0;
            r_flast <= i_item.frame_last;
            for (int d = 0; d < KD; d++) begin
                for (int e = 0; e < KD; e++) begin
                    if (i_item.first || e == 0) begin
                        r_win[d][e] <= i_item.col[d];
                    end else begin
                        r_win[d][e] <= r_win[d][e-1];
                    end
                end
            end
        end else if (w_en && r_busy && !w_last) begin
            r_d <= r_d - 2'd1;
        end
    end

    always_comb begin
        int off;
        logic [2:0] row;
        logic signed [CW-1:0] c;
        off = 0;
        row = '0;
        c   = '0;
        for (int i = 0; i < KD; i++) begin
            for (int j = 0; j < KD; j++) begin
                off = int'(r_d) + int'(i_half) - j;
                if (off < 0) begin
                    off = 0;
                end
                if (off > KD - 1) begin
                    off = KD - 1;
                end
                row = (3'(i) < i_k) ? i_k - 3'd1 - 3'(i) : 3'd0;
                c = ((3'(i) < i_k) && (3'(j) < i_k)) ? i_coef[i][CW*j +: CW] : '0;
                w_prod[i][j] = $signed({1'b0, r_win[row][3'(off)]}) * c;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < KD; i++) begin
            w_rsum[i] = '0;
            for (int j = 0; j < KD; j++) begin
                w_rsum[i] = w_rsum[i] + SW'(r_prod[i][j]);
            end
        end
        w_total = '0;
        for (int i = 0; i < KD; i++) begin
            w_total = w_total + r_rsum[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_s_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_p_vld <= r_busy;
            r_s_vld <= r_p_vld;
            r_o_vld <= r_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod  <= w_prod;
            r_p_lor <= w_last;
            r_p_lof <= r_flast && w_last;
            r_rsum  <= w_rsum;
            r_s_lor <= r_p_lor;
            r_s_lof <= r_p_lof;
            r_o_sum <= w_total;
            r_o_lor <= r_s_lor;
            r_o_lof <= r_s_lof;
        end
    end

    assign o_valid         = r_o_vld;
    assign o_filtered      = r_o_sum;
    assign o_last_of_run   = r_o_lor;
    assign o_last_of_frame = r_o_lof;

`ifndef SYNTHESIS
    a_seq_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_d >= r_dend)
        else $error("result sequencer ran past its last column");
`endif

endmodule

### design/conv2d_replicate_border.sv
// conv2d_replicate_border: streaming 2d convolution, up to 5x5, replicate padding
// datapath: front buffer, column queue, window, then product, row-sum and output registers
// throughput: one input word per cycle; a row-end word releases up to three results,
//   one per cycle while i_stall is low, and the input stalls once the 4-entry column
//   queue fills
// reset: synchronous active-low; clears counters and pipeline valids, restores config
// depends on c2rb_pkg, c2rb_front, c2rb_fifo, c2rb_back, c2rb_ram

module conv2d_replicate_border #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 5
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_cmd,
    input  logic [c2rb_pkg::PIX_W-1:0]             i_pixel,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [c2rb_pkg::SUM_W-1:0]      o_filtered,
    output logic                                   o_last_of_run,
    output logic                                   o_last_of_frame,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [c2rb_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [c2rb_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [10:0]                r_frame_width;
    logic [15:0]                r_frame_height;
    logic [2:0]                 r_kernel_size;
    c2rb_pkg::t_coef_rows       r_coef;

    logic                       w_cfg_we;
    logic                       w_restart;
    logic [AW-1:0]              w_wm1;
    logic [15:0]                w_h;
    logic [2:0]                 w_k;
    logic [1:0]                 w_half;
    logic [1:0]                 w_ahead;
    logic                       w_full;
    logic                       w_push;
    logic                       w_nonempty;
    logic                       w_pop;
    c2rb_pkg::t_col_item        w_push_item;
    c2rb_pkg::t_col_item        w_head_item;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign w_restart   = w_cfg_we && (i_cfg_index == c2rb_pkg::REG_FRAME_WIDTH ||
                                      i_cfg_index == c2rb_pkg::REG_FRAME_HEIGHT ||
                                      i_cfg_index == c2rb_pkg::REG_KERNEL_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 11'd1024;
            r_frame_height <= 16'd1024;
            r_kernel_size  <= 3'd3;
            r_coef         <= '0;
        end else if (w_cfg_we) begin
            case (i_cfg_index)
                c2rb_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[10:0];
                c2rb_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[15:0];
                c2rb_pkg::REG_KERNEL_SIZE:  r_kernel_size  <= i_cfg_data[2:0];
                c2rb_pkg::REG_KERNEL_ROW0:  r_coef[0]      <= i_cfg_data;
                c2rb_pkg::REG_KERNEL_ROW1:  r_coef[1]      <= i_cfg_data;
                c2rb_pkg::REG_KERNEL_ROW2:  r_coef[2]      <= i_cfg_data;
                c2rb_pkg::REG_KERNEL_ROW3:  r_coef[3]      <= i_cfg_data;
                c2rb_pkg::REG_KERNEL_ROW4:  r_coef[4]      <= i_cfg_data;
                default:                    r_coef         <= r_coef;
            endcase
        end
    end

    always_comb begin
        if (r_frame_width == 11'd0) begin
            w_wm1 = '0;
        end else if (int'(r_frame_width) > MAX_WIDTH) begin
            w_wm1 = AW'(MAX_WIDTH - 1);
        end else begin
            w_wm1 = AW'(r_frame_width - 11'd1);
        end
        w_h = (r_frame_height == 16'd0) ? 16'd1 : r_frame_height;
        if (r_kernel_size == 3'd0) begin
            w_k = 3'd1;
        end else if (int'(r_kernel_size) > MAX_KERNEL) begin
            w_k = 3'(MAX_KERNEL);
        end else begin
            w_k = r_kernel_size;
        end
        w_half  = w_k[2:1];
        w_ahead = 2'(w_k - 3'd1 - {1'b0, w_half});
    end

    c2rb_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_cmd     (i_cmd),
        .i_pixel   (i_pixel),
        .i_wm1     (w_wm1),
        .i_h       (w_h),
        .i_ahead   (w_ahead),
        .i_restart (w_restart),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_item    (w_push_item)
    );

    c2rb_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_item     (w_push_item),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_nonempty (w_nonempty),
        .o_item     (w_head_item)
    );

    c2rb_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_nonempty      (w_nonempty),
        .i_item          (w_head_item),
        .o_pop           (w_pop),
        .i_k             (w_k),
        .i_half          (w_half),
        .i_coef          (r_coef),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_filtered      (o_filtered),
        .o_last_of_run   (o_last_of_run),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule
